// ----- rtl/psf_pkg.sv -----
package psf_pkg;

  // Table geometry.
  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Packet format and sequence constants.
  localparam logic [7:0]  VALID_LENGTH  = 8'd50;
  localparam logic [15:0] WRAP_MIDPOINT = 16'd32767;

  // Configuration reset values and port widths.
  localparam logic [15:0] TIMEOUT_RESET = 16'd40;
  localparam logic [7:0]  TYPE_RESET    = 8'd1;
  localparam int          CFG_DATA_W    = 16;
  localparam int          CFG_IDX_W     = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_TYPE    = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    V_ACCEPTED = 3'd0,
    V_STALE    = 3'd1,
    V_IGNORED  = 3'd2,
    V_FULL     = 3'd3,
    V_REMOVED  = 3'd4
  } verdict_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_PICK,
    S_EMIT
  } state_e;

  // Per-slot fields kept in the entry memory.
  typedef struct packed {
    logic [15:0] last_seq;
    logic [31:0] arrival;
  } entry_t;

  // Result of a sender lookup in the id table.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } cam_look_t;

  // Update request for the id table.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic [15:0]      sender;
  } cam_wr_t;

endpackage

// ----- rtl/psf_if.sv -----
// Input word channel: one packet header or tick.
interface psf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  packet_length;
  logic [7:0]  packet_type;
  logic [15:0] sequence_number;
  logic [15:0] sender_id;
  logic [7:0]  vehicle_kind;

  modport source (
    output valid, opcode, packet_length, packet_type, sequence_number, sender_id,
           vehicle_kind,
    input  ready
  );
  modport sink (
    input  valid, opcode, packet_length, packet_type, sequence_number, sender_id,
           vehicle_kind,
    output ready
  );
endinterface

// Result word channel.
interface psf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [15:0] result_sender;
  logic [7:0]  result_kind;
  logic        first_seen;
  logic        last_of_run;

  modport source (
    output valid, verdict, result_sender, result_kind, first_seen, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, verdict, result_sender, result_kind, first_seen, last_of_run,
    output ready
  );
endinterface

// ----- rtl/psf_entry_ram.sv -----
module psf_entry_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/psf_sender_cam.sv -----
module psf_sender_cam import psf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      lookup_sender_i,
  output cam_look_t        look_o,
  input  cam_wr_t          wr_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [15:0]      rd_sender_o,
  output logic [SLOTS-1:0] valid_o
);

  logic [SLOTS-1:0] valid_q;
  logic [15:0]      sender_q [SLOTS];

  // Valid bits are cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.set) begin
      valid_q[wr_i.idx] <= 1'b1;
    end else if (wr_i.clr) begin
      valid_q[wr_i.idx] <= 1'b0;
    end
  end

  // Sender ids are only read while their slot is valid.
  always_ff @(posedge clk_i) begin
    if (wr_i.set) begin
      sender_q[wr_i.idx] <= wr_i.sender;
    end
  end

  // Parallel match and lowest free slot; scanning downward leaves the lowest index.
  always_comb begin
    look_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && (sender_q[i] == lookup_sender_i)) begin
        look_o.hit     = 1'b1;
        look_o.hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        look_o.free     = 1'b1;
        look_o.free_idx = IDX_W'(i);
      end
    end
  end

  assign rd_sender_o = sender_q[rd_idx_i];
  assign valid_o     = valid_q;

endmodule

// ----- rtl/per_sender_sequence_filter.sv -----
// Packet header: one result word per packet; the next packet is taken only after it is loaded.
// Tick: an expiry scan over the entry memory (one read port, one slot a cycle),
// then, for each removal, a serial lowest-id search over the slots.
// Results wait in an output register, so a stalled sink only holds the current step.
// Reset clears all slot valid bits and the seconds counter and loads the default
// timeout and packet type; no memory clearing pass is needed.
module per_sender_sequence_filter import psf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  psf_in_if.sink                in_if,
  psf_out_if.source             out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e           state_q, state_d;
  logic [15:0]      timeout_q;
  logic [7:0]       type_q;
  logic [31:0]      cur_q, cur_d;
  cam_look_t        look_q, look_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SLOTS-1:0] expired_q, expired_d;
  logic             best_found_q, best_found_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [15:0]      best_snd_q, best_snd_d;

  // Captured packet word.
  logic [7:0]  len_q, ptype_q, kind_q;
  logic [15:0] seq_q, snd_q;

  // Output register.
  logic        out_valid_q, out_valid_d;
  verdict_e    verdict_q, verdict_d;
  logic [15:0] res_snd_q, res_snd_d;
  logic [7:0]  res_kind_q, res_kind_d;
  logic        first_q, first_d;
  logic        last_q, last_d;

  logic             in_acc;
  logic             out_free;
  cam_look_t        cam_look;
  cam_wr_t          cam_wr;
  logic [IDX_W-1:0] cam_rd_idx;
  logic [15:0]      cam_rd_snd;
  logic [SLOTS-1:0] valid;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, rd_entry;
  logic [$bits(entry_t)-1:0] ram_rdata;

  logic             stale;
  logic [IDX_W-1:0] chk_idx;
  logic [31:0]      age;
  logic [SLOTS-1:0] rest;

  psf_sender_cam u_cam (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .lookup_sender_i (in_if.sender_id),
    .look_o          (cam_look),
    .wr_i            (cam_wr),
    .rd_idx_i        (cam_rd_idx),
    .rd_sender_o     (cam_rd_snd),
    .valid_o         (valid)
  );

  psf_entry_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry    = entry_t'(ram_rdata);
  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;

  // Stale check against the stored sequence number, with the wrap exception.
  assign stale = (rd_entry.last_seq > seq_q) &&
                 !((rd_entry.last_seq > WRAP_MIDPOINT) && (seq_q < WRAP_MIDPOINT));

  // Expiry scan evaluates the slot read in the previous cycle.
  assign chk_idx = IDX_W'(cnt_q - CNT_W'(1));
  assign age     = cur_q - rd_entry.arrival;

  // Expired set without the slot being removed now.
  always_comb begin
    rest             = expired_q;
    rest[best_idx_q] = 1'b0;
  end

  // Sequencer: next state, memory and table accesses, result loading.
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    look_d       = look_q;
    cnt_d        = cnt_q;
    expired_d    = expired_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_snd_d   = best_snd_q;
    out_valid_d  = out_valid_q && !out_if.ready;
    verdict_d    = verdict_q;
    res_snd_d    = res_snd_q;
    res_kind_d   = res_kind_q;
    first_d      = first_q;
    last_d       = last_q;
    cam_wr       = '0;
    cam_rd_idx   = cnt_q[IDX_W-1:0];
    ram_we       = 1'b0;
    ram_waddr    = look_q.hit ? look_q.hit_idx : look_q.free_idx;
    ram_wdata    = '{last_seq: seq_q, arrival: cur_q};
    ram_re       = 1'b0;
    ram_raddr    = cam_look.hit_idx;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_e'(in_if.opcode) == OP_TICK) begin
            cur_d     = cur_q + 32'd1;
            cnt_d     = '0;
            expired_d = '0;
            state_d   = S_SCAN;
          end else begin
            ram_re  = 1'b1;
            look_d  = cam_look;
            state_d = S_DEC;
          end
        end
      end

      S_DEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_snd_d   = snd_q;
          res_kind_d  = 8'd0;
          first_d     = 1'b0;
          last_d      = 1'b1;
          if ((len_q != VALID_LENGTH) || (ptype_q != type_q)) begin
            verdict_d = V_IGNORED;
          end else if (look_q.hit && stale) begin
            verdict_d = V_STALE;
          end else if (!look_q.hit && !look_q.free) begin
            verdict_d = V_FULL;
          end else begin
            verdict_d     = V_ACCEPTED;
            res_kind_d    = kind_q;
            first_d       = !look_q.hit;
            ram_we        = 1'b1;
            cam_wr.set    = !look_q.hit;
            cam_wr.idx    = look_q.free_idx;
            cam_wr.sender = snd_q;
          end
          state_d = S_IDLE;
        end
      end

      S_SCAN: begin
        if (cnt_q < CNT_W'(SLOTS)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[IDX_W-1:0];
        end
        if (cnt_q != '0) begin
          expired_d[chk_idx] = valid[chk_idx] && (age >= {16'd0, timeout_q});
        end
        if (cnt_q == CNT_W'(SLOTS)) begin
          cnt_d        = '0;
          best_found_d = 1'b0;
          state_d      = (expired_d != '0) ? S_PICK : S_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      S_PICK: begin
        if (expired_q[cnt_q[IDX_W-1:0]] && (!best_found_q || (cam_rd_snd < best_snd_q))) begin
          best_found_d = 1'b1;
          best_idx_d   = cnt_q[IDX_W-1:0];
          best_snd_d   = cam_rd_snd;
        end
        if (cnt_q == CNT_W'(SLOTS - 1)) begin
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          verdict_d             = V_REMOVED;
          res_snd_d             = best_snd_q;
          res_kind_d            = 8'd0;
          first_d               = 1'b0;
          last_d                = (rest == '0);
          cam_wr.clr            = 1'b1;
          cam_wr.idx            = best_idx_q;
          expired_d[best_idx_q] = 1'b0;
          cnt_d                 = '0;
          best_found_d          = 1'b0;
          state_d               = (rest == '0) ? S_IDLE : S_PICK;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      cnt_q        <= '0;
      expired_q    <= '0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      cnt_q        <= cnt_d;
      expired_q    <= expired_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      type_q    <= TYPE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT: timeout_q <= cfg_data_i[15:0];
        CFG_TYPE:    type_q    <= cfg_data_i[7:0];
        default:     ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      len_q   <= in_if.packet_length;
      ptype_q <= in_if.packet_type;
      seq_q   <= in_if.sequence_number;
      snd_q   <= in_if.sender_id;
      kind_q  <= in_if.vehicle_kind;
    end
    look_q     <= look_d;
    best_idx_q <= best_idx_d;
    best_snd_q <= best_snd_d;
    verdict_q  <= verdict_d;
    res_snd_q  <= res_snd_d;
    res_kind_q <= res_kind_d;
    first_q    <= first_d;
    last_q     <= last_d;
  end

  // Result word.
  assign out_if.valid         = out_valid_q;
  assign out_if.verdict       = verdict_q;
  assign out_if.result_sender = res_snd_q;
  assign out_if.result_kind   = res_kind_q;
  assign out_if.first_seen    = first_q;
  assign out_if.last_of_run   = last_q;

endmodule
